>>> src/sctlm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and command/status definitions for the sector cache directory.
package sctlm_pkg;

    localparam int MAX_ENTRIES  = 4096;
    localparam int HASH_BUCKETS = 16384;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int PTR_W        = IDX_W + 1;
    localparam int BKT_W        = $clog2(HASH_BUCKETS);
    localparam int CNT_W        = 13;
    localparam int CFG_IDX_W    = 2;

    localparam logic [PTR_W-1:0] NIL_PTR   = '1;
    localparam logic [7:0]       BAD_DRIVE = 8'hFF;

    localparam logic [1:0] KIND_PROBE   = 2'd0;
    localparam logic [1:0] KIND_FILL    = 2'd1;
    localparam logic [1:0] KIND_WRITE   = 2'd2;
    localparam logic [1:0] KIND_WB_DONE = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FLUSH     = 2'd1;
    localparam logic [1:0] STAT_NO_VICTIM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRTY_THRESHOLD = 2'd1;

    localparam logic [CNT_W-1:0] RST_ENTRIES_IN_USE  = 13'd4096;
    localparam logic [CNT_W-1:0] RST_DIRTY_THRESHOLD = 13'd3687;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      sector;
        logic [7:0]       drive;
        logic             dirty;
        logic [IDX_W-1:0] target_entry;
        logic             discard;
    } sctlm_in_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] entry_index;
        logic [1:0]       status;
        logic             evicted;
        logic [CNT_W-1:0] dirty_count;
    } sctlm_out_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_WB_READ,
        OP_WB_APPLY,
        OP_LK_HEAD,
        OP_LK_FIRST,
        OP_LK_STEP,
        OP_HIT,
        OP_ST_NEW,
        OP_REFUSE_FLUSH,
        OP_REFUSE_NO_VICTIM,
        OP_V_START,
        OP_V_STEP,
        OP_U_HEAD,
        OP_U_FIRST,
        OP_U_STEP,
        OP_P_HEAD,
        OP_P_WRITE,
        OP_MN_READ,
        OP_MN_LINK1,
        OP_MN_LINK2,
        OP_MN_LINK3,
        OP_FINISH
    } sctlm_op_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] kind;
        logic       bad_drive;
        logic       empty;
        logic       head_null;
        logic       lk_match;
        logic       lk_end;
        logic       need_mn;
        logic       cap_zero;
        logic       room;
        logic       over_thr;
        logic       oldest_null;
        logic       v_found;
        logic       v_end;
        logic       u_head_hit;
        logic       u_head_null;
        logic       u_found;
        logic       u_end;
        logic       is_newest;
        logic       out_free;
    } sctlm_stat_t;

    function automatic logic ptr_null(input logic [PTR_W-1:0] p);
        return !(p < PTR_W'(MAX_ENTRIES));
    endfunction

endpackage

>>> src/sctlm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sctlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sctlm_dp.sv
`timescale 1ns / 1ps
// Datapath: directory memories, pointers, counters and result register.
module sctlm_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sctlm_pkg::sctlm_op_t               op,
    output sctlm_pkg::sctlm_stat_t             stat,
    input  sctlm_pkg::sctlm_in_t               s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sctlm_pkg::sctlm_out_t              m_data,
    input  logic                               cfg_valid,
    input  logic [sctlm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sctlm_pkg::CNT_W-1:0]        cfg_data
);

    localparam int IW = sctlm_pkg::IDX_W;
    localparam int PW = sctlm_pkg::PTR_W;
    localparam int BW = sctlm_pkg::BKT_W;
    localparam int CW = sctlm_pkg::CNT_W;

    sctlm_pkg::sctlm_in_t  req_reg;
    sctlm_pkg::sctlm_out_t out_reg;
    logic                  out_valid_reg;

    logic [PW-1:0] cur_reg, oldest_reg, newest_reg, vnext_reg;
    logic [IW-1:0] idx_reg, steps_reg;
    logic [BW-1:0] vbkt_reg, clr_reg;
    logic [CW-1:0] used_reg, total_reg, eiu_reg, thr_reg, cap;
    logic [1:0]    status_reg;
    logic          hit_reg, evict_reg, dm_reg, dval;

    // memory ports
    logic          bh_we;
    logic [BW-1:0] bh_waddr, bh_raddr;
    logic [PW-1:0] bh_wdata, bh_rd;
    logic [IW-1:0] ent_raddr;
    logic          tag_we, drv_we, nxt_we, old_we, new_we, dm_we;
    logic [IW-1:0] drv_waddr, nxt_waddr, old_waddr, new_waddr, dm_waddr;
    logic [31:0]   tag_rd;
    logic [7:0]    drv_wdata, drv_rd;
    logic [PW-1:0] nxt_wdata, nxt_rd, old_wdata, old_rd, new_wdata, new_rd;
    logic          dm_wdata, dm_rd;
    logic          steps_last;

    assign cap        = (eiu_reg > CW'(sctlm_pkg::MAX_ENTRIES)) ?
                        CW'(sctlm_pkg::MAX_ENTRIES) : eiu_reg;
    assign dval       = (req_reg.kind == sctlm_pkg::KIND_WRITE) ? req_reg.dirty : 1'b0;
    assign steps_last = (steps_reg == '1);

    always_comb begin
        bh_we     = 1'b0;
        bh_waddr  = req_reg.sector[BW-1:0];
        bh_wdata  = {1'b0, idx_reg};
        bh_raddr  = req_reg.sector[BW-1:0];
        ent_raddr = idx_reg;
        tag_we    = 1'b0;
        drv_we    = 1'b0;
        drv_waddr = idx_reg;
        drv_wdata = req_reg.drive;
        nxt_we    = 1'b0;
        nxt_waddr = idx_reg;
        nxt_wdata = bh_rd;
        old_we    = 1'b0;
        old_waddr = idx_reg;
        old_wdata = newest_reg;
        new_we    = 1'b0;
        new_waddr = idx_reg;
        new_wdata = sctlm_pkg::NIL_PTR;
        dm_we     = 1'b0;
        dm_waddr  = idx_reg;
        dm_wdata  = dval;
        case (op)
            sctlm_pkg::OP_CLEAR: begin
                bh_we    = 1'b1;
                bh_waddr = clr_reg;
                bh_wdata = sctlm_pkg::NIL_PTR;
                if (clr_reg < BW'(sctlm_pkg::MAX_ENTRIES)) begin
                    drv_we    = 1'b1;
                    drv_waddr = clr_reg[IW-1:0];
                    drv_wdata = sctlm_pkg::BAD_DRIVE;
                    old_we    = 1'b1;
                    old_waddr = clr_reg[IW-1:0];
                    old_wdata = sctlm_pkg::NIL_PTR;
                    new_we    = 1'b1;
                    new_waddr = clr_reg[IW-1:0];
                    dm_we     = 1'b1;
                    dm_waddr  = clr_reg[IW-1:0];
                    dm_wdata  = 1'b0;
                end
            end
            sctlm_pkg::OP_WB_READ: ent_raddr = req_reg.target_entry;
            sctlm_pkg::OP_WB_APPLY: begin
                dm_we     = dm_rd;
                dm_waddr  = req_reg.target_entry;
                dm_wdata  = 1'b0;
                drv_we    = req_reg.discard;
                drv_waddr = req_reg.target_entry;
                drv_wdata = sctlm_pkg::BAD_DRIVE;
            end
            sctlm_pkg::OP_LK_FIRST: ent_raddr = bh_rd[IW-1:0];
            sctlm_pkg::OP_LK_STEP:  ent_raddr = nxt_rd[IW-1:0];
            sctlm_pkg::OP_HIT: begin
                dm_we    = (req_reg.kind == sctlm_pkg::KIND_WRITE);
                dm_wdata = req_reg.dirty;
            end
            sctlm_pkg::OP_V_START: ent_raddr = oldest_reg[IW-1:0];
            sctlm_pkg::OP_V_STEP:  ent_raddr = new_rd[IW-1:0];
            sctlm_pkg::OP_U_HEAD:  bh_raddr = vbkt_reg;
            sctlm_pkg::OP_U_FIRST: begin
                bh_waddr  = vbkt_reg;
                bh_wdata  = vnext_reg;
                bh_we     = (bh_rd == {1'b0, idx_reg});
                ent_raddr = bh_rd[IW-1:0];
            end
            sctlm_pkg::OP_U_STEP: begin
                nxt_we    = (nxt_rd == {1'b0, idx_reg});
                nxt_waddr = cur_reg[IW-1:0];
                nxt_wdata = vnext_reg;
                ent_raddr = nxt_rd[IW-1:0];
            end
            sctlm_pkg::OP_P_WRITE: begin
                nxt_we = 1'b1;
                bh_we  = 1'b1;
                tag_we = 1'b1;
                drv_we = 1'b1;
                dm_we  = 1'b1;
            end
            sctlm_pkg::OP_MN_LINK1: begin
                new_we    = !sctlm_pkg::ptr_null(old_rd);
                new_waddr = old_rd[IW-1:0];
                new_wdata = new_rd;
                old_we    = !sctlm_pkg::ptr_null(new_rd);
                old_waddr = new_rd[IW-1:0];
                old_wdata = old_rd;
            end
            sctlm_pkg::OP_MN_LINK2: begin
                old_we    = 1'b1;
                new_we    = !sctlm_pkg::ptr_null(newest_reg);
                new_waddr = newest_reg[IW-1:0];
                new_wdata = {1'b0, idx_reg};
            end
            sctlm_pkg::OP_MN_LINK3: new_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            total_reg     <= '0;
            oldest_reg    <= sctlm_pkg::NIL_PTR;
            newest_reg    <= sctlm_pkg::NIL_PTR;
            eiu_reg       <= sctlm_pkg::RST_ENTRIES_IN_USE;
            thr_reg       <= sctlm_pkg::RST_DIRTY_THRESHOLD;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == sctlm_pkg::CFG_ENTRIES_IN_USE) begin
                    eiu_reg <= cfg_data;
                end else if (cfg_index == sctlm_pkg::CFG_DIRTY_THRESHOLD) begin
                    thr_reg <= cfg_data;
                end
            end
            if (out_valid_reg && m_ready && op != sctlm_pkg::OP_FINISH) begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                sctlm_pkg::OP_CLEAR: clr_reg <= clr_reg + BW'(1);
                sctlm_pkg::OP_ACCEPT: begin
                    req_reg    <= s_data;
                    steps_reg  <= '0;
                    hit_reg    <= 1'b0;
                    idx_reg    <= '0;
                    status_reg <= sctlm_pkg::STAT_OK;
                    evict_reg  <= 1'b0;
                end
                sctlm_pkg::OP_WB_APPLY: begin
                    idx_reg <= req_reg.target_entry;
                    if (dm_rd && total_reg != '0) begin
                        total_reg <= total_reg - CW'(1);
                    end
                end
                sctlm_pkg::OP_LK_FIRST: cur_reg <= bh_rd;
                sctlm_pkg::OP_LK_STEP: begin
                    if (stat.lk_match) begin
                        idx_reg <= cur_reg[IW-1:0];
                        dm_reg  <= dm_rd;
                        hit_reg <= 1'b1;
                    end else begin
                        cur_reg   <= nxt_rd;
                        steps_reg <= steps_reg + IW'(1);
                    end
                end
                sctlm_pkg::OP_HIT: begin
                    if (req_reg.kind == sctlm_pkg::KIND_WRITE) begin
                        if (!dm_reg && req_reg.dirty) begin
                            total_reg <= total_reg + CW'(1);
                        end else if (dm_reg && !req_reg.dirty && total_reg != '0) begin
                            total_reg <= total_reg - CW'(1);
                        end
                    end
                end
                sctlm_pkg::OP_ST_NEW: begin
                    idx_reg  <= used_reg[IW-1:0];
                    used_reg <= used_reg + CW'(1);
                end
                sctlm_pkg::OP_REFUSE_FLUSH:     status_reg <= sctlm_pkg::STAT_FLUSH;
                sctlm_pkg::OP_REFUSE_NO_VICTIM: status_reg <= sctlm_pkg::STAT_NO_VICTIM;
                sctlm_pkg::OP_V_START: begin
                    cur_reg   <= oldest_reg;
                    steps_reg <= '0;
                end
                sctlm_pkg::OP_V_STEP: begin
                    if (!dm_rd) begin
                        idx_reg   <= cur_reg[IW-1:0];
                        vnext_reg <= nxt_rd;
                        vbkt_reg  <= tag_rd[BW-1:0];
                        evict_reg <= 1'b1;
                    end else begin
                        cur_reg   <= new_rd;
                        steps_reg <= steps_reg + IW'(1);
                    end
                end
                sctlm_pkg::OP_U_FIRST: begin
                    cur_reg   <= bh_rd;
                    steps_reg <= '0;
                end
                sctlm_pkg::OP_U_STEP: begin
                    cur_reg   <= nxt_rd;
                    steps_reg <= steps_reg + IW'(1);
                end
                sctlm_pkg::OP_P_WRITE: begin
                    if (dval) begin
                        total_reg <= total_reg + CW'(1);
                    end
                end
                sctlm_pkg::OP_MN_LINK1: begin
                    if (sctlm_pkg::ptr_null(oldest_reg)) begin
                        oldest_reg <= {1'b0, idx_reg};
                    end else if (oldest_reg == {1'b0, idx_reg}) begin
                        oldest_reg <= new_rd;
                    end
                end
                sctlm_pkg::OP_MN_LINK3: newest_reg <= {1'b0, idx_reg};
                sctlm_pkg::OP_FINISH: begin
                    out_valid_reg       <= 1'b1;
                    out_reg.hit         <= hit_reg;
                    out_reg.entry_index <= idx_reg;
                    out_reg.status      <= status_reg;
                    out_reg.evicted     <= evict_reg;
                    out_reg.dirty_count <= total_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        stat.clr_last    = (clr_reg == '1);
        stat.kind        = req_reg.kind;
        stat.bad_drive   = (req_reg.drive == sctlm_pkg::BAD_DRIVE);
        stat.empty       = (used_reg == '0);
        stat.head_null   = sctlm_pkg::ptr_null(bh_rd);
        stat.lk_match    = (tag_rd == req_reg.sector) && (drv_rd == req_reg.drive);
        stat.lk_end      = sctlm_pkg::ptr_null(nxt_rd) || steps_last;
        stat.need_mn     = (req_reg.kind == sctlm_pkg::KIND_PROBE) ||
                           (req_reg.kind == sctlm_pkg::KIND_WRITE) || dm_reg;
        stat.cap_zero    = (cap == '0);
        stat.room        = (used_reg < cap);
        stat.over_thr    = (total_reg >= thr_reg);
        stat.oldest_null = sctlm_pkg::ptr_null(oldest_reg);
        stat.v_found     = !dm_rd;
        stat.v_end       = sctlm_pkg::ptr_null(new_rd) || steps_last;
        stat.u_head_hit  = (bh_rd == {1'b0, idx_reg});
        stat.u_head_null = sctlm_pkg::ptr_null(bh_rd);
        stat.u_found     = (nxt_rd == {1'b0, idx_reg});
        stat.u_end       = sctlm_pkg::ptr_null(nxt_rd) || steps_last;
        stat.is_newest   = (newest_reg == {1'b0, idx_reg});
        stat.out_free    = !out_valid_reg || m_ready;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    sctlm_ram #(.WIDTH(PW), .DEPTH(sctlm_pkg::HASH_BUCKETS)) u_bucket_head (
        .aclk(aclk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
        .raddr(bh_raddr), .rdata(bh_rd)
    );
    sctlm_ram #(.WIDTH(32), .DEPTH(sctlm_pkg::MAX_ENTRIES)) u_sector_tag (
        .aclk(aclk), .we(tag_we), .waddr(idx_reg), .wdata(req_reg.sector),
        .raddr(ent_raddr), .rdata(tag_rd)
    );
    sctlm_ram #(.WIDTH(8), .DEPTH(sctlm_pkg::MAX_ENTRIES)) u_drive_tag (
        .aclk(aclk), .we(drv_we), .waddr(drv_waddr), .wdata(drv_wdata),
        .raddr(ent_raddr), .rdata(drv_rd)
    );
    sctlm_ram #(.WIDTH(PW), .DEPTH(sctlm_pkg::MAX_ENTRIES)) u_bucket_next (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(ent_raddr), .rdata(nxt_rd)
    );
    sctlm_ram #(.WIDTH(PW), .DEPTH(sctlm_pkg::MAX_ENTRIES)) u_lru_older (
        .aclk(aclk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
        .raddr(ent_raddr), .rdata(old_rd)
    );
    sctlm_ram #(.WIDTH(PW), .DEPTH(sctlm_pkg::MAX_ENTRIES)) u_lru_newer (
        .aclk(aclk), .we(new_we), .waddr(new_waddr), .wdata(new_wdata),
        .raddr(ent_raddr), .rdata(new_rd)
    );
    sctlm_ram #(.WIDTH(1), .DEPTH(sctlm_pkg::MAX_ENTRIES)) u_dirty_mark (
        .aclk(aclk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(ent_raddr), .rdata(dm_rd)
    );

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(sctlm_pkg::MAX_ENTRIES))
        else $error("used count beyond entry count");
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= used_reg)
        else $error("dirty count beyond used entries");
    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (op != sctlm_pkg::OP_ST_NEW) |=> $stable(used_reg))
        else $error("used count moved outside allocation");
    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == sctlm_pkg::OP_FINISH) |=> out_valid_reg)
        else $error("result lost at finish");

endmodule

>>> src/sctlm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: runs writeback-done, lookup, victim search, insert and LRU update steps.
module sctlm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sctlm_pkg::sctlm_stat_t stat,
    output sctlm_pkg::sctlm_op_t   op
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_WB_RD, ST_WB_AP, ST_LK_HEAD, ST_LK_FIRST,
        ST_LK_STEP, ST_HIT, ST_ST_DECIDE, ST_ST_NEW, ST_REF_FLUSH, ST_REF_NOVIC,
        ST_V_START, ST_V_STEP, ST_U_HEAD, ST_U_FIRST, ST_U_STEP, ST_P_HEAD, ST_P_WRITE,
        ST_MN_READ, ST_MN_L1, ST_MN_L2, ST_MN_L3, ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    state_t miss_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign miss_state = (stat.kind == sctlm_pkg::KIND_PROBE) ? ST_FINISH : ST_ST_DECIDE;

    always_comb begin
        state_next = state_reg;
        op         = sctlm_pkg::OP_NONE;
        case (state_reg)
            ST_CLEAR: begin
                op = sctlm_pkg::OP_CLEAR;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op         = sctlm_pkg::OP_ACCEPT;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.kind == sctlm_pkg::KIND_WB_DONE) state_next = ST_WB_RD;
                else if (stat.bad_drive)                  state_next = ST_FINISH;
                else if (stat.empty)                      state_next = miss_state;
                else                                      state_next = ST_LK_HEAD;
            end
            ST_WB_RD: begin
                op         = sctlm_pkg::OP_WB_READ;
                state_next = ST_WB_AP;
            end
            ST_WB_AP: begin
                op         = sctlm_pkg::OP_WB_APPLY;
                state_next = ST_FINISH;
            end
            ST_LK_HEAD: begin
                op         = sctlm_pkg::OP_LK_HEAD;
                state_next = ST_LK_FIRST;
            end
            ST_LK_FIRST: begin
                op         = sctlm_pkg::OP_LK_FIRST;
                state_next = stat.head_null ? miss_state : ST_LK_STEP;
            end
            ST_LK_STEP: begin
                op = sctlm_pkg::OP_LK_STEP;
                if (stat.lk_match)    state_next = ST_HIT;
                else if (stat.lk_end) state_next = miss_state;
            end
            ST_HIT: begin
                op         = sctlm_pkg::OP_HIT;
                state_next = stat.need_mn ? ST_MN_READ : ST_FINISH;
            end
            ST_ST_DECIDE: begin
                if (stat.cap_zero)      state_next = ST_REF_NOVIC;
                else if (stat.room)     state_next = ST_ST_NEW;
                else if (stat.over_thr) state_next = ST_REF_FLUSH;
                else                    state_next = ST_V_START;
            end
            ST_ST_NEW: begin
                op         = sctlm_pkg::OP_ST_NEW;
                state_next = ST_P_HEAD;
            end
            ST_REF_FLUSH: begin
                op         = sctlm_pkg::OP_REFUSE_FLUSH;
                state_next = ST_FINISH;
            end
            ST_REF_NOVIC: begin
                op         = sctlm_pkg::OP_REFUSE_NO_VICTIM;
                state_next = ST_FINISH;
            end
            ST_V_START: begin
                op         = sctlm_pkg::OP_V_START;
                state_next = stat.oldest_null ? ST_REF_NOVIC : ST_V_STEP;
            end
            ST_V_STEP: begin
                op = sctlm_pkg::OP_V_STEP;
                if (stat.v_found)    state_next = ST_U_HEAD;
                else if (stat.v_end) state_next = ST_REF_NOVIC;
            end
            ST_U_HEAD: begin
                op         = sctlm_pkg::OP_U_HEAD;
                state_next = ST_U_FIRST;
            end
            ST_U_FIRST: begin
                op = sctlm_pkg::OP_U_FIRST;
                if (stat.u_head_hit || stat.u_head_null) state_next = ST_P_HEAD;
                else                                     state_next = ST_U_STEP;
            end
            ST_U_STEP: begin
                op = sctlm_pkg::OP_U_STEP;
                if (stat.u_found || stat.u_end) state_next = ST_P_HEAD;
            end
            ST_P_HEAD: begin
                op         = sctlm_pkg::OP_P_HEAD;
                state_next = ST_P_WRITE;
            end
            ST_P_WRITE: begin
                op         = sctlm_pkg::OP_P_WRITE;
                state_next = ST_MN_READ;
            end
            ST_MN_READ: begin
                op         = sctlm_pkg::OP_MN_READ;
                state_next = stat.is_newest ? ST_FINISH : ST_MN_L1;
            end
            ST_MN_L1: begin
                op         = sctlm_pkg::OP_MN_LINK1;
                state_next = ST_MN_L2;
            end
            ST_MN_L2: begin
                op         = sctlm_pkg::OP_MN_LINK2;
                state_next = ST_MN_L3;
            end
            ST_MN_L3: begin
                op         = sctlm_pkg::OP_MN_LINK3;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    op         = sctlm_pkg::OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted transaction not dispatched");
    a_clear_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("input taken during clearing pass");
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == sctlm_pkg::OP_FINISH) |=> (state_reg == ST_IDLE))
        else $error("finish did not return to idle");

endmodule

>>> src/sector_cache_tag_lru_manager_core.sv
`timescale 1ns / 1ps
// Top level of the sector cache directory: hashed lookup, LRU order, dirty tracking.
// After reset the block runs a clearing pass, one bucket head per cycle, before s_ready
// rises; configuration writes are taken at any time. One transaction is in flight at a
// time, and each returns exactly one result. A transaction is accepted, dispatched and
// handed off as a result (later while the previous result waits for m_ready). A lookup
// reads the bucket head and then visits one bucket-chain entry per cycle; a hit, a move
// of an entry to the newest LRU position and an insert into a free entry follow as
// needed. A refused store sets its status and finishes. Replacement examines LRU
// entries from the oldest end, one per cycle, then passes bucket-chain entries while
// unlinking the victim, then writes it. A writeback-done transaction reads the dirty
// mark of its target entry, clears it and, with discard set, invalidates its drive tag.
// Each directory RAM has a single read port with registered read data.
module sector_cache_tag_lru_manager_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sctlm_pkg::sctlm_in_t            s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sctlm_pkg::sctlm_out_t           m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sctlm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sctlm_pkg::CNT_W-1:0]     cfg_data
);

    sctlm_pkg::sctlm_op_t   op;
    sctlm_pkg::sctlm_stat_t stat;

    assign cfg_ready = 1'b1;

    sctlm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .op(op)
    );

    sctlm_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .op(op), .stat(stat), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

endmodule
